>>> src/scma_pkg.sv
// Shared constants and types for the six-channel moving average.
// No dependencies; compiled first.
package scma_pkg;

    // Width of the window_size configuration register.
    localparam int CFG_BITS = 5;

    // window_size after reset.
    localparam logic [CFG_BITS-1:0] WINDOW_RESET = 5'd10;

    // Point x/y/z and direction x/y/z.
    localparam int NUM_CH  = 6;
    localparam int CH_BITS = 3;

    typedef logic [CH_BITS-1:0] ch_idx_t;

    localparam ch_idx_t LAST_CH = ch_idx_t'(NUM_CH - 1);

endpackage

>>> src/scma_in_if.sv
// Input channel: one line estimate per item, valid/ready handshake.
// Depends on nothing; sample width is an interface parameter.
interface scma_in_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic                          line_present;
    logic signed [SAMPLE_BITS-1:0] point_x;
    logic signed [SAMPLE_BITS-1:0] point_y;
    logic signed [SAMPLE_BITS-1:0] point_z;
    logic signed [SAMPLE_BITS-1:0] dir_x;
    logic signed [SAMPLE_BITS-1:0] dir_y;
    logic signed [SAMPLE_BITS-1:0] dir_z;

    modport source (
        output valid, line_present, point_x, point_y, point_z, dir_x, dir_y, dir_z,
        input  ready
    );

    modport sink (
        input  valid, line_present, point_x, point_y, point_z, dir_x, dir_y, dir_z,
        output ready
    );
endinterface

>>> src/scma_out_if.sv
// Output channel: channel means and entry count, valid/ready handshake.
// Depends on nothing; widths are interface parameters.
interface scma_out_if #(
    parameter int SAMPLE_BITS = 16,
    parameter int COUNT_BITS  = 5
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] avg_point_x;
    logic signed [SAMPLE_BITS-1:0] avg_point_y;
    logic signed [SAMPLE_BITS-1:0] avg_point_z;
    logic signed [SAMPLE_BITS-1:0] avg_dir_x;
    logic signed [SAMPLE_BITS-1:0] avg_dir_y;
    logic signed [SAMPLE_BITS-1:0] avg_dir_z;
    logic        [COUNT_BITS-1:0]  entries_used;

    modport source (
        output valid, avg_point_x, avg_point_y, avg_point_z,
               avg_dir_x, avg_dir_y, avg_dir_z, entries_used,
        input  ready
    );

    modport sink (
        input  valid, avg_point_x, avg_point_y, avg_point_z,
               avg_dir_x, avg_dir_y, avg_dir_z, entries_used,
        output ready
    );
endinterface

>>> src/scma_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module scma_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> src/six_channel_moving_average.sv
// Six-channel moving average of line estimates (point and direction, Q3.12).
// Depends on scma_pkg, scma_in_if, scma_out_if and scma_ram.
//
// Usage:
//   estimate : input item channel (valid/ready). An item with line_present
//              low is taken and dropped; it yields no result.
//   average  : result channel (valid/ready). One result per item with a line:
//              six channel means, truncated toward zero, and entries_used.
//   cfg_we / cfg_wdata : writes window_size (0 acts as 1, values above
//              WINDOW_MAX act as WINDOW_MAX). Write only while idle.
// Timing: ready is high only while idle. An item with a line first drops old
//   entries as the window requires (none or one in steady state), then stores
//   and adds the new entry and divides each channel sum in turn. The next item
//   is taken only after the result has been taken. One shared add/subtract
//   unit does every step, one division bit per cycle.
// Reset: window_size returns to 10, the history becomes empty and the sums
//   clear. Stored entries are never read before being written.
// Stall: the result is held in output registers until taken; no new item is
//   accepted meanwhile.
module six_channel_moving_average #(
    parameter int WINDOW_MAX  = 16,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [scma_pkg::CFG_BITS-1:0]     cfg_wdata,
    scma_in_if.sink                           estimate,
    scma_out_if.source                        average
);

    import scma_pkg::*;

    localparam int PTR_BITS  = $clog2(WINDOW_MAX);
    localparam int CNT_BITS  = $clog2(WINDOW_MAX + 1);
    localparam int SLOT_BITS = CNT_BITS + 1;
    // Sum of WINDOW_MAX samples never leaves this range.
    localparam int SUM_BITS  = SAMPLE_BITS + $clog2(WINDOW_MAX);
    localparam int ALU_BITS  = SUM_BITS + 1;
    localparam int STEP_BITS = $clog2(SUM_BITS);
    localparam int WORD_BITS = NUM_CH * SAMPLE_BITS;

    typedef enum logic [2:0] {
        S_IDLE,   // waiting for an item
        S_CHECK,  // drop oldest or store new entry
        S_POP,    // subtract dropped entry, one channel per cycle
        S_ADD,    // add new entry, one channel per cycle
        S_NEG,    // take magnitude of channel sum
        S_DIV,    // restoring division, one quotient bit per cycle
        S_FIX,    // restore sign of quotient
        S_OUT     // result waiting for the receiver
    } state_t;

    state_t                        state_reg, state_next;
    logic [CFG_BITS-1:0]           window_size_reg, window_size_next;
    logic [PTR_BITS-1:0]           oldest_reg, oldest_next;
    logic [CNT_BITS-1:0]           count_reg, count_next;
    ch_idx_t                       ch_reg, ch_next;
    logic signed [SUM_BITS-1:0]    sum_reg [NUM_CH];
    logic signed [SUM_BITS-1:0]    sum_next [NUM_CH];
    logic signed [SAMPLE_BITS-1:0] samp_reg [NUM_CH];
    logic signed [SAMPLE_BITS-1:0] samp_next [NUM_CH];
    logic signed [SAMPLE_BITS-1:0] avg_reg [NUM_CH];
    logic signed [SAMPLE_BITS-1:0] avg_next [NUM_CH];
    logic [SUM_BITS-1:0]           dvd_reg, dvd_next;    // dividend, then quotient
    logic [CNT_BITS-1:0]           rem_reg, rem_next;
    logic [STEP_BITS-1:0]          step_reg, step_next;
    logic                          neg_reg, neg_next;

    // Shared add/subtract unit.
    logic signed [ALU_BITS-1:0]    alu_a, alu_b, alu_y;
    logic                          alu_sub;

    // History memory.
    logic                          ram_we;
    logic [PTR_BITS-1:0]           ram_waddr;
    logic [WORD_BITS-1:0]          ram_wdata, ram_rdata;

    logic [CNT_BITS-1:0]           win_eff;
    int                            win_int;
    logic [SLOT_BITS-1:0]          slot_sum, oldest_inc;
    logic signed [SUM_BITS-1:0]    cur_sum;
    logic signed [SAMPLE_BITS-1:0] pop_sample;
    logic [CNT_BITS:0]             rem_shift;
    logic                          div_ge;

    assign alu_y = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);

    scma_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (WINDOW_MAX)
    ) u_history (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (oldest_reg),   // always reads the oldest entry
        .rdata (ram_rdata)
    );

    // Effective window: zero acts as one, clamp at WINDOW_MAX.
    always_comb
    begin
        win_int = int'(window_size_reg);
        if (win_int == 0)
        begin
            win_int = 1;
        end
        else if (win_int > WINDOW_MAX)
        begin
            win_int = WINDOW_MAX;
        end
        win_eff = CNT_BITS'(win_int);
    end

    // Ring pointer arithmetic; both sums stay below twice the depth.
    always_comb
    begin
        slot_sum = SLOT_BITS'(oldest_reg) + SLOT_BITS'(count_reg);
        if (slot_sum >= SLOT_BITS'(WINDOW_MAX))
        begin
            slot_sum = slot_sum - SLOT_BITS'(WINDOW_MAX);
        end
        oldest_inc = SLOT_BITS'(oldest_reg) + SLOT_BITS'(1);
        if (oldest_inc >= SLOT_BITS'(WINDOW_MAX))
        begin
            oldest_inc = '0;
        end
    end

    assign ram_waddr  = slot_sum[PTR_BITS-1:0];
    assign cur_sum    = sum_reg[ch_reg];
    assign pop_sample = ram_rdata[int'(ch_reg) * SAMPLE_BITS +: SAMPLE_BITS];
    assign rem_shift  = {rem_reg, dvd_reg[SUM_BITS-1]};

    always_comb
    begin
        for (int i = 0; i < NUM_CH; i++)
        begin
            ram_wdata[i*SAMPLE_BITS +: SAMPLE_BITS] = samp_reg[i];
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next       = state_reg;
        window_size_next = window_size_reg;
        oldest_next      = oldest_reg;
        count_next       = count_reg;
        ch_next          = ch_reg;
        sum_next         = sum_reg;
        samp_next        = samp_reg;
        avg_next         = avg_reg;
        dvd_next         = dvd_reg;
        rem_next         = rem_reg;
        step_next        = step_reg;
        neg_next         = neg_reg;
        alu_a            = '0;
        alu_b            = '0;
        alu_sub          = 1'b0;
        ram_we           = 1'b0;
        div_ge           = 1'b0;

        if (cfg_we)
        begin
            window_size_next = cfg_wdata;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (estimate.valid && estimate.line_present)
                begin
                    samp_next[0] = estimate.point_x;
                    samp_next[1] = estimate.point_y;
                    samp_next[2] = estimate.point_z;
                    samp_next[3] = estimate.dir_x;
                    samp_next[4] = estimate.dir_y;
                    samp_next[5] = estimate.dir_z;
                    state_next   = S_CHECK;
                end
            end

            S_CHECK:
            begin
                ch_next = '0;
                if (count_reg >= win_eff)
                begin
                    // oldest entry's data shows up on the read port next cycle
                    state_next = S_POP;
                end
                else
                begin
                    ram_we     = 1'b1;
                    state_next = S_ADD;
                end
            end

            S_POP:
            begin
                alu_a   = ALU_BITS'(cur_sum);
                alu_b   = ALU_BITS'(pop_sample);
                alu_sub = 1'b1;
                sum_next[ch_reg] = alu_y[SUM_BITS-1:0];
                if (ch_reg == LAST_CH)
                begin
                    oldest_next = oldest_inc[PTR_BITS-1:0];
                    count_next  = count_reg - CNT_BITS'(1);
                    state_next  = S_CHECK;
                end
                else
                begin
                    ch_next = ch_reg + ch_idx_t'(1);
                end
            end

            S_ADD:
            begin
                alu_a = ALU_BITS'(cur_sum);
                alu_b = ALU_BITS'(samp_reg[ch_reg]);
                sum_next[ch_reg] = alu_y[SUM_BITS-1:0];
                if (ch_reg == LAST_CH)
                begin
                    count_next = count_reg + CNT_BITS'(1);
                    ch_next    = '0;
                    state_next = S_NEG;
                end
                else
                begin
                    ch_next = ch_reg + ch_idx_t'(1);
                end
            end

            S_NEG:
            begin
                alu_b    = ALU_BITS'(cur_sum);
                alu_sub  = 1'b1;
                neg_next = cur_sum[SUM_BITS-1];
                dvd_next = cur_sum[SUM_BITS-1] ? alu_y[SUM_BITS-1:0] : cur_sum;
                rem_next = '0;
                step_next  = '0;
                state_next = S_DIV;
            end

            S_DIV:
            begin
                alu_a   = ALU_BITS'(rem_shift);
                alu_b   = ALU_BITS'(count_reg);
                alu_sub = 1'b1;
                div_ge  = !alu_y[ALU_BITS-1];
                rem_next = div_ge ? alu_y[CNT_BITS-1:0] : rem_shift[CNT_BITS-1:0];
                dvd_next = {dvd_reg[SUM_BITS-2:0], div_ge};
                if (step_reg == STEP_BITS'(SUM_BITS - 1))
                begin
                    state_next = S_FIX;
                end
                else
                begin
                    step_next = step_reg + STEP_BITS'(1);
                end
            end

            S_FIX:
            begin
                alu_b   = ALU_BITS'(dvd_reg);
                alu_sub = neg_reg;
                avg_next[ch_reg] = alu_y[SAMPLE_BITS-1:0];
                if (ch_reg == LAST_CH)
                begin
                    ch_next    = '0;
                    state_next = S_OUT;
                end
                else
                begin
                    ch_next    = ch_reg + ch_idx_t'(1);
                    state_next = S_NEG;
                end
            end

            S_OUT:
            begin
                if (average.ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            window_size_reg <= WINDOW_RESET;
            oldest_reg      <= '0;
            count_reg       <= '0;
            ch_reg          <= '0;
            dvd_reg         <= '0;
            rem_reg         <= '0;
            step_reg        <= '0;
            neg_reg         <= 1'b0;
            for (int i = 0; i < NUM_CH; i++)
            begin
                sum_reg[i]  <= '0;
                samp_reg[i] <= '0;
                avg_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg       <= state_next;
            window_size_reg <= window_size_next;
            oldest_reg      <= oldest_next;
            count_reg       <= count_next;
            ch_reg          <= ch_next;
            dvd_reg         <= dvd_next;
            rem_reg         <= rem_next;
            step_reg        <= step_next;
            neg_reg         <= neg_next;
            sum_reg         <= sum_next;
            samp_reg        <= samp_next;
            avg_reg         <= avg_next;
        end
    end

    // Channel hookup.
    assign estimate.ready       = (state_reg == S_IDLE);
    assign average.valid        = (state_reg == S_OUT);
    assign average.avg_point_x  = avg_reg[0];
    assign average.avg_point_y  = avg_reg[1];
    assign average.avg_point_z  = avg_reg[2];
    assign average.avg_dir_x    = avg_reg[3];
    assign average.avg_dir_y    = avg_reg[4];
    assign average.avg_dir_z    = avg_reg[5];
    assign average.entries_used = count_reg;

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the six-channel moving average of line estimates.
// Depends on scma_pkg, scma_in_if, scma_out_if and six_channel_moving_average.
module tb_top;
    import scma_pkg::*;

    localparam int WINDOW_MAX    = 16;
    localparam int SAMPLE_BITS   = 16;
    // Covers the slowest item, one that drops a full history.
    localparam int SETTLE_CYCLES = 300;
    localparam int HOLD_CYCLES   = 800;
    localparam int PHASE_ITEMS   = 160;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    // One line estimate; channels are point x/y/z then direction x/y/z.
    typedef struct {
        bit      line;
        sample_t sample [NUM_CH];
    } estimate_t;

    typedef struct {
        sample_t             mean [NUM_CH];
        logic [CFG_BITS-1:0] count;
    } window_mean_t;

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [CFG_BITS-1:0] cfg_wdata;

    scma_in_if  #(.SAMPLE_BITS(SAMPLE_BITS)) estimate_bus ();
    scma_out_if #(.SAMPLE_BITS(SAMPLE_BITS), .COUNT_BITS(CFG_BITS)) average_bus ();

    six_channel_moving_average #(
        .WINDOW_MAX  (WINDOW_MAX),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .estimate  (estimate_bus),
        .average   (average_bus)
    );

    // ------------------------------------------------------------------
    // Predictor state: window register, history ring, running sums.
    // ------------------------------------------------------------------
    logic [CFG_BITS-1:0] window_setting = WINDOW_RESET;
    sample_t             history_ring [WINDOW_MAX][NUM_CH];
    logic [3:0]          oldest_slot    = '0;
    int unsigned         stored_count   = 0;
    longint              running_sum [NUM_CH] = '{default: 0};

    // Means still owed by the block, oldest first.
    window_mean_t        mean_queue [$];

    string chan_name [NUM_CH] = '{"avg_point_x", "avg_point_y", "avg_point_z",
                                  "avg_dir_x", "avg_dir_y", "avg_dir_z"};

    int error_count     = 0;
    int line_items      = 0;
    int ignored_items   = 0;
    int results_checked = 0;
    int window_writes   = 0;

    // Receiver control: hold-off requests from the tests, the receiver's own
    // count of them, and the rotating stall pattern.
    int          hold_requests = 0;
    int          hold_served   = 0;
    int          hold_left     = 0;
    int          pat_age       = 0;
    logic [15:0] stall_pat     = '1;

    // Drop oldest entries until there is room, store the new estimate and
    // return the per-channel means over what is stored.
    function automatic window_mean_t advance_window(input estimate_t e);
        int unsigned  limit;
        logic [3:0]   slot;
        window_mean_t r;
        // Zero acts as one, anything above the ring depth as the ring depth.
        if (window_setting == 0)
            limit = 1;
        else if (window_setting > WINDOW_MAX)
            limit = WINDOW_MAX;
        else
            limit = window_setting;
        // A shrunk window is only enforced here, oldest first.
        while (stored_count >= limit && stored_count > 0)
        begin
            for (int c = 0; c < NUM_CH; c++)
                running_sum[c] -= history_ring[oldest_slot][c];
            oldest_slot = oldest_slot + 4'd1;
            stored_count--;
        end
        slot = oldest_slot + 4'(stored_count);
        for (int c = 0; c < NUM_CH; c++)
        begin
            history_ring[slot][c] = e.sample[c];
            running_sum[c] += e.sample[c];
        end
        stored_count++;
        // longint division truncates toward zero
        for (int c = 0; c < NUM_CH; c++)
            r.mean[c] = sample_t'(running_sum[c] / longint'(stored_count));
        r.count = CFG_BITS'(stored_count);
        return r;
    endfunction

    function automatic sample_t rand_sample();
        case ($urandom_range(0, 7))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return '0;
            default: return sample_t'($urandom);
        endcase
    endfunction

    function automatic estimate_t random_estimate(input bit line);
        estimate_t e;
        e.line = line;
        for (int c = 0; c < NUM_CH; c++)
            e.sample[c] = rand_sample();
        return e;
    endfunction

    function automatic estimate_t uniform_estimate(input bit line, input sample_t v);
        estimate_t e;
        e.line = line;
        for (int c = 0; c < NUM_CH; c++)
            e.sample[c] = v;
        return e;
    endfunction

    task automatic report_mismatch(input string what, input longint want, input longint got);
        $display("[%0t] MISMATCH %s: expected %0d, got %0d", $time, what, want, got);
        error_count++;
    endtask

    // ------------------------------------------------------------------
    // Sender side. Every task is entered and left just after a rising edge.
    // Valid is left high on return so back-to-back items need no re-raise.
    // ------------------------------------------------------------------
    task automatic send_item(input estimate_t e);
        estimate_bus.valid        <= 1'b1;
        estimate_bus.line_present <= e.line;
        estimate_bus.point_x      <= e.sample[0];
        estimate_bus.point_y      <= e.sample[1];
        estimate_bus.point_z      <= e.sample[2];
        estimate_bus.dir_x        <= e.sample[3];
        estimate_bus.dir_y        <= e.sample[4];
        estimate_bus.dir_z        <= e.sample[5];
        do
            @(posedge clk);
        while (!estimate_bus.ready);
        // accepted at this edge
        if (e.line)
        begin
            mean_queue.insert(mean_queue.size(), advance_window(e));
            line_items++;
        end
        else
            ignored_items++;
    endtask

    task automatic pause_sender(input int cycles);
        estimate_bus.valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Sender waits for every owed mean, then lets an ignored item finish too.
    task automatic wait_idle();
        estimate_bus.valid <= 1'b0;
        while (mean_queue.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_window(input logic [CFG_BITS-1:0] w);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= w;
        @(posedge clk);
        cfg_we         <= 1'b0;
        window_setting  = w;
        window_writes++;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Window after reset is 10: eleven estimates force one drop. Extremes of
    // every channel, a mixed estimate and two ignored items are included.
    task automatic test_default_window();
        estimate_t e;
        send_item(uniform_estimate(1'b1, 16'sh7FFF));
        send_item(uniform_estimate(1'b1, 16'sh8000));
        send_item(uniform_estimate(1'b1, 16'sh0000));
        send_item(uniform_estimate(1'b1, 16'shFFFF));
        send_item(random_estimate(1'b0));
        e.line   = 1'b1;
        e.sample = '{16'sh7FFF, 16'sh8000, 16'sh0001, 16'shFFFF, 16'sh1234, -16'sh1234};
        send_item(e);
        repeat (5) send_item(random_estimate(1'b1));
        // ignored item with every payload bit set
        send_item(uniform_estimate(1'b0, 16'shFFFF));
        send_item(random_estimate(1'b1));
        wait_idle();
    endtask

    // A window of zero acts as one: each mean equals the newest estimate.
    task automatic test_window_zero();
        set_window('0);
        send_item(uniform_estimate(1'b1, 16'sh8000));
        send_item(random_estimate(1'b1));
        send_item(random_estimate(1'b1));
    endtask

    // Register all ones is clamped to the ring depth.
    task automatic test_window_above_max();
        set_window('1);
        repeat (4) send_item(random_estimate(1'b1));
        wait_idle();
    endtask

    // Receiver holds off far longer than one item takes; the sender keeps
    // offering, so the held result must stall the input.
    task automatic test_result_hold_off();
        hold_requests++;
        repeat (5) send_item(random_estimate(1'b1));
        wait_idle();
    endtask

    // Random estimates over a sequence of window settings. Sixteen followed by
    // one drops a full history in one go. Bursts of random length with gaps,
    // one phase without gaps, and occasional runs of one extreme value that
    // push the sums to their limits.
    task automatic test_random_windows();
        logic [CFG_BITS-1:0] plan [8];
        int                  sent;
        int                  burst_left;
        int                  streak_left;
        sample_t             streak_val;
        estimate_t           e;
        plan    = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd17, 5'd2, 5'd10, 5'd16};
        plan[6] = CFG_BITS'($urandom_range(3, 15));
        streak_val = '0;
        for (int p = 0; p < 8; p++)
        begin
            set_window(plan[p]);
            sent        = 0;
            burst_left  = 0;
            streak_left = 0;
            while (sent < PHASE_ITEMS)
            begin
                if (burst_left == 0)
                begin
                    if (p != 3)
                        pause_sender(($urandom_range(0, 3) == 0) ? $urandom_range(1, 160)
                                                                 : $urandom_range(1, 8));
                    burst_left = $urandom_range(1, 16);
                    if ($urandom_range(0, 9) == 0)
                    begin
                        streak_left = WINDOW_MAX;
                        streak_val  = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
                    end
                end
                burst_left--;
                if (streak_left > 0)
                begin
                    e = uniform_estimate(1'b1, streak_val);
                    streak_left--;
                end
                else
                    e = random_estimate($urandom_range(0, 99) >= 15);
                send_item(e);
                if (e.line)
                    sent++;
            end
        end
        wait_idle();
    endtask

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Receiver: rotating stall pattern, re-drawn after a random age;
    // some patterns never stall. A hold-off request overrides the pattern
    // and is counted down here.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (hold_served != hold_requests)
        begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            average_bus.ready <= 1'b0;
        end
        else
        begin
            if (pat_age == 0)
            begin
                pat_age   = $urandom_range(32, 256);
                stall_pat = ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                                        : (16'($urandom | $urandom) | 16'h1);
            end
            pat_age--;
            average_bus.ready <= stall_pat[0];
            stall_pat = {stall_pat[0], stall_pat[15:1]};
        end
    end

    // ------------------------------------------------------------------
    // Result checker: each accepted result against the oldest owed mean.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : check_results
        sample_t      got [NUM_CH];
        window_mean_t want;
        if (rst_n && average_bus.valid && average_bus.ready)
        begin
            got = '{average_bus.avg_point_x, average_bus.avg_point_y, average_bus.avg_point_z,
                    average_bus.avg_dir_x, average_bus.avg_dir_y, average_bus.avg_dir_z};
            if (mean_queue.size() == 0)
                report_mismatch("result with none owed, entries_used", 0,
                                average_bus.entries_used);
            else
            begin
                want = mean_queue[0];
                mean_queue.delete(0);
                for (int c = 0; c < NUM_CH; c++)
                    if (got[c] !== want.mean[c])
                        report_mismatch(chan_name[c], want.mean[c], got[c]);
                if (average_bus.entries_used !== want.count)
                    report_mismatch("entries_used", want.count, average_bus.entries_used);
                results_checked++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n                     <= 1'b0;
        cfg_we                    <= 1'b0;
        cfg_wdata                 <= '0;
        estimate_bus.valid        <= 1'b0;
        estimate_bus.line_present <= 1'b0;
        estimate_bus.point_x      <= '0;
        estimate_bus.point_y      <= '0;
        estimate_bus.point_z      <= '0;
        estimate_bus.dir_x        <= '0;
        estimate_bus.dir_y        <= '0;
        estimate_bus.dir_z        <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_window();
        test_window_zero();
        test_window_above_max();
        test_result_hold_off();
        test_random_windows();

        // everything owed has arrived; nothing may be left over
        wait_idle();
        if (mean_queue.size() != 0)
            report_mismatch("means never delivered", 0, mean_queue.size());

        $display("Run covered %0d estimates with a line and %0d ignored items, %0d results checked,",
                 line_items, ignored_items, results_checked);
        $display("over %0d window writes including zero, one, sixteen and out-of-range values.",
                 window_writes);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Watchdog: several times the slowest correct run.
    initial
    begin
        #25_000_000;
        $display("Timeout: %0d means still owed", mean_queue.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
